// ----- design/sh3x3_pkg.sv -----
// ----------------------------------------------------------------------------
// sh3x3_pkg: shared types and constants of the 3x3 sharpen stencil
// Pixel width, configuration register codes, reset values and the default
// image limits used by the stencil and its line buffers.
// ----------------------------------------------------------------------------
package sh3x3_pkg;

  localparam int PIX_BITS  = 8;
  localparam int IMG_W_BITS = 12;
  localparam int IMG_H_BITS = 13;
  localparam int CFG_DATA_BITS = 13;

  localparam int DEFAULT_MAX_WIDTH  = 2048;
  localparam int DEFAULT_MAX_HEIGHT = 4096;

  // Smallest image side that still has an interior pixel.
  localparam int MIN_DIM = 3;

  localparam logic [IMG_W_BITS-1:0] IMAGE_WIDTH_RESET  = 12'd640;
  localparam logic [IMG_H_BITS-1:0] IMAGE_HEIGHT_RESET = 13'd480;

  localparam logic [PIX_BITS-1:0] PIX_MAX = 8'd255;

  typedef logic [PIX_BITS-1:0] pixel_t;

  // The 3x3 neighbourhood around one center pixel.
  typedef struct packed {
    pixel_t top_left;
    pixel_t top;
    pixel_t top_right;
    pixel_t left;
    pixel_t center;
    pixel_t right;
    pixel_t bot_left;
    pixel_t bot;
    pixel_t bot_right;
  } window_t;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

endpackage

// ----- design/sharpen_3x3_stencil.sv -----
// ----------------------------------------------------------------------------
// sharpen_3x3_stencil: 3x3 Laplacian sharpen over a raster pixel stream
// Line buffers, window registers and kernel for an 8-bit grayscale image.
// ----------------------------------------------------------------------------
// The block takes one 8-bit pixel word per clock in raster order while
// in_stall is low and, for every interior pixel, returns one word one row
// and one column later: eight times the center minus its eight
// neighbours, clamped to 0..255, with the center's column and row and a
// flag on the last interior pixel of the frame. Border pixels give no
// output word. Throughput is one pixel per clock while in_stall is low.
// An accepted pixel passes the read stage, with its synchronous
// line-buffer reads, then the kernel, which feeds the output register.
// Width and height are set through the write port; a write restarts the
// frame at row zero, column zero. Either size below 3 acts as 3 and values
// above MAX_WIDTH or MAX_HEIGHT act as those limits. No clearing pass
// is needed after reset: each line-buffer row is rewritten before use.
module sharpen_3x3_stencil
  import sh3x3_pkg::*;
#(
  parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT),
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                     clk,
  input  logic                     rst,

  input  logic                     cfg_wr_en,
  input  logic [0:0]               cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,

  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [PIX_BITS-1:0]      pixel_in,

  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [PIX_BITS-1:0]      pixel_out,
  output logic [CW-1:0]            out_col,
  output logic [RW-1:0]            out_row,
  output logic                     frame_last
);

  // Configuration registers and their clamped working values.
  logic [IMG_W_BITS-1:0] image_width;
  logic [IMG_H_BITS-1:0] image_height;
  logic [WW-1:0]         width_eff;
  logic [HW-1:0]         height_eff;

  // Position of the next pixel in the frame.
  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic [CW-1:0] col_count_next;
  logic [RW-1:0] row_count_next;
  logic          row_end;
  logic          frame_end;

  // Read stage: the pixel waits here while its column is read from the
  // line buffers.
  logic          s1_valid;
  pixel_t        s1_px;
  logic [CW-1:0] s1_col;
  logic [RW-1:0] s1_row;
  logic          s1_emit;
  logic          s1_last;

  pixel_t  top_rd;
  pixel_t  mid_rd;
  pixel_t  win [6];
  window_t kwin;
  pixel_t  sharp;

  logic accept;
  logic out_free;
  logic s1_adv;

  always_comb begin
    if (32'(image_width) < MIN_DIM) begin
      width_eff = WW'(MIN_DIM);
    end else if (32'(image_width) > MAX_WIDTH) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(image_width);
    end
    if (32'(image_height) < MIN_DIM) begin
      height_eff = HW'(MIN_DIM);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      height_eff = HW'(MAX_HEIGHT);
    end else begin
      height_eff = HW'(image_height);
    end
  end

  // The output register frees up when it is empty or its word is taken.
  // A pixel with no result leaves the read stage without waiting for it.
  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && (!s1_emit || out_free);
  assign in_stall = s1_valid && !s1_adv;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    row_end   = (WW'(col_count) + WW'(1)) == width_eff;
    frame_end = row_end && ((HW'(row_count) + HW'(1)) == height_eff);
    if (row_end) begin
      col_count_next = '0;
      row_count_next = frame_end ? '0 : row_count + RW'(1);
    end else begin
      col_count_next = col_count + CW'(1);
      row_count_next = row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RESET;
      image_height <= IMAGE_HEIGHT_RESET;
      col_count    <= '0;
      row_count    <= '0;
    end else if (cfg_wr_en) begin
      // Any register write restarts the frame.
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[IMG_W_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[IMG_H_BITS-1:0];
        default: ;
      endcase
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px   <= pixel_in;
      s1_col  <= col_count;
      s1_row  <= row_count;
      s1_emit <= (32'(col_count) >= 2) && (32'(row_count) >= 2);
      s1_last <= frame_end;
    end
  end

  // Line buffers: the read for a pixel is issued as it is accepted, and the
  // write back happens as it leaves the read stage. Consecutive pixels
  // always sit in different columns, so a read never meets a pending write
  // to the same address.
  sh3x3_linebuf #(
    .DEPTH(MAX_WIDTH)
  ) u_line_two_above (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_count),
    .rd_data (top_rd),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data (mid_rd)
  );

  sh3x3_linebuf #(
    .DEPTH(MAX_WIDTH)
  ) u_line_above (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_count),
    .rd_data (mid_rd),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data (s1_px)
  );

  // Window columns: entries 0..2 are the oldest column (top to bottom),
  // entries 3..5 the middle one. The newest column comes straight from the
  // line-buffer read data and the pixel in the read stage.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top_rd;
      win[4] <= mid_rd;
      win[5] <= s1_px;
    end
  end

  always_comb begin
    kwin.top_left  = win[0];
    kwin.left      = win[1];
    kwin.bot_left  = win[2];
    kwin.top       = win[3];
    kwin.center    = win[4];
    kwin.bot       = win[5];
    kwin.top_right = top_rd;
    kwin.right     = mid_rd;
    kwin.bot_right = s1_px;
  end

  sh3x3_kernel u_kernel (
    .win (kwin),
    .pix (sharp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid && s1_emit;
    end
  end

  // The center sits one column left of and one row above the newest pixel.
  always_ff @(posedge clk) begin
    if (out_free && s1_valid && s1_emit) begin
      pixel_out  <= sharp;
      out_col    <= s1_col - CW'(1);
      out_row    <= s1_row - RW'(1);
      frame_last <= s1_last;
    end
  end

endmodule

// ----- design/sh3x3_linebuf.sv -----
// ----------------------------------------------------------------------------
// sh3x3_linebuf: one row of pixel storage
// Single write port and one read port with registered read data. The read
// data holds while no read is requested.
// ----------------------------------------------------------------------------
module sh3x3_linebuf
  import sh3x3_pkg::*;
#(
  parameter int DEPTH = DEFAULT_MAX_WIDTH,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output pixel_t        rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  pixel_t        wr_data
);

  pixel_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/sh3x3_kernel.sv -----
// ----------------------------------------------------------------------------
// sh3x3_kernel: Laplacian sharpen of one 3x3 window
// Eight times the center minus the eight neighbours, clamped to 0..255.
// ----------------------------------------------------------------------------
module sh3x3_kernel
  import sh3x3_pkg::*;
(
  input  window_t win,
  output pixel_t  pix
);

  // Eight pixels of 255 sum to 2040, which fits in 11 bits.
  logic [10:0] nsum;
  logic [10:0] center_x8;
  logic [11:0] diff;

  always_comb begin
    nsum = 11'(win.top_left) + 11'(win.top) + 11'(win.top_right)
         + 11'(win.left) + 11'(win.right)
         + 11'(win.bot_left) + 11'(win.bot) + 11'(win.bot_right);
    center_x8 = {win.center, 3'b000};
    diff = {1'b0, center_x8} - {1'b0, nsum};
    if (diff[11]) begin
      pix = '0;
    end else if (diff[10:8] != 3'b000) begin
      pix = PIX_MAX;
    end else begin
      pix = diff[7:0];
    end
  end

endmodule
